FILE: hw/rtl/sccb_pkg.sv
// shared types, constants and codes of the size class block cache
`timescale 1ns / 1ps
package sccb_pkg;

	localparam int NUM_CLASSES = 64;
	localparam int NUM_ENTRIES = 32;
	localparam int UNIT_SHIFT = 3;

	localparam int CLS_W = $clog2(NUM_CLASSES);
	localparam int ENT_W = $clog2(NUM_ENTRIES);
	localparam int LNK_W = $clog2(NUM_ENTRIES + 1);
	localparam int HANDLE_W = 48;
	localparam int SIZE_W = 24;
	localparam int BCLS_W = 7;
	localparam int CLS_FULL_W = SIZE_W - UNIT_SHIFT;
	localparam int REQ_W = 25;
	localparam int UNITS_W = 22;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = '0;
	localparam logic [UNITS_W-1:0] LIMIT_RESET = 22'd2097152;
	localparam logic [BCLS_W-1:0] OVERSIZED_CODE = 7'd64;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_COLLECT = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_CACHED   = 3'd2,
		ST_OVERSIZE = 3'd3,
		ST_FLUSH    = 3'd4,
		ST_CORRUPT  = 3'd5,
		ST_COLLECT  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_POP,
		S_FLUSH_RD,
		S_FLUSH_EM,
		S_REREAD,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [SIZE_W-1:0]   size_bytes;
		logic [HANDLE_W-1:0] handle;
		logic [BCLS_W-1:0]   block_class;
		logic                header_ok;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] out_handle;
		logic [BCLS_W-1:0]   size_class;
		logic [REQ_W-1:0]    request_bytes;
		logic [UNITS_W-1:0]  cached_units;
		logic                last;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		out_item_t        item;
	} emit_t;

	typedef struct packed {
		logic             re;
		logic [CLS_W-1:0] raddr;
		logic             we;
		logic [CLS_W-1:0] waddr;
		logic [LNK_W-1:0] wdata;
	} class_req_t;

	typedef struct packed {
		logic             re;
		logic [ENT_W-1:0] raddr;
		logic             we;
		logic [ENT_W-1:0] waddr;
		logic [LNK_W-1:0] wdata;
	} link_req_t;

	typedef struct packed {
		logic                re;
		logic [ENT_W-1:0]    raddr;
		logic                we;
		logic [ENT_W-1:0]    waddr;
		logic [HANDLE_W-1:0] wdata;
	} hdl_req_t;

endpackage

FILE: hw/rtl/sccb_ram.sv
// generic single write, single read synchronous ram
`timescale 1ns / 1ps
module sccb_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/sccb_ctrl.sv
// sequencer for lookups, list updates and flushes of the block cache
`timescale 1ns / 1ps
module sccb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sccb_pkg::in_item_t            in_item,
	input  logic                          out_ready,
	output sccb_pkg::emit_t               emit,
	input  logic [sccb_pkg::UNITS_W-1:0]  limit,
	output sccb_pkg::class_req_t          class_req,
	input  logic [sccb_pkg::LNK_W-1:0]    class_rd,
	output sccb_pkg::link_req_t           link_req,
	input  logic [sccb_pkg::LNK_W-1:0]    link_rd,
	output sccb_pkg::hdl_req_t            hdl_req,
	input  logic [sccb_pkg::HANDLE_W-1:0] hdl_rd
);

	localparam int CW = sccb_pkg::CLS_W;
	localparam int EW = sccb_pkg::ENT_W;
	localparam int LW = sccb_pkg::LNK_W;
	localparam int UW = sccb_pkg::UNITS_W;
	localparam int NE = sccb_pkg::NUM_ENTRIES;
	localparam int NC = sccb_pkg::NUM_CLASSES;
	localparam int FW = sccb_pkg::CLS_FULL_W;

	function automatic logic [LW-1:0] link_reset(input logic [EW-1:0] idx);
		logic [LW-1:0] nxt;
		nxt = LW'(idx) + LW'(1);
		return (int'(nxt) < NE) ? nxt + LW'(1) : '0;
	endfunction

	sccb_pkg::state_t state_q, state_d;
	logic [LW-1:0]    fh_q, fh_d;
	logic [UW-1:0]    total_q, total_d;
	logic [EW-1:0]    cursor_q, cursor_d;
	logic [NC-1:0]    cvalid_q, cvalid_d;
	logic [NE-1:0]    lvalid_q, lvalid_d;
	logic [NE-1:0]    occ_q, occ_d;
	logic             collect_q, collect_d;
	logic             flushed_q, flushed_d;

	sccb_pkg::in_item_t item_q;
	logic [FW-1:0]      cls_q;
	logic [EW-1:0]      pop_e_q, pop_e_d;
	logic [LW-1:0]      pop_head_q, pop_head_d;
	logic [EW-1:0]      lrd_idx_q, lrd_idx_d;
	logic               load;

	logic [sccb_pkg::SIZE_W-1:0] size_m1;
	logic [FW-1:0]      cls_in;
	logic [CW-1:0]      cidx;
	logic [LW-1:0]      class_val;
	logic [LW-1:0]      link_val;
	logic [LW-1:0]      fh_m1;
	logic [EW-1:0]      fh_e;
	logic               cls_big;
	logic [UW-1:0]      dec;
	logic [UW-1:0]      total_sub;
	logic [UW:0]        sum;
	logic [UW-1:0]      total_add;
	logic [UW-1:0]      cls_units;

	assign size_m1 = in_item.size_bytes - sccb_pkg::SIZE_W'(1);
	assign cls_in = (in_item.size_bytes == '0) ? '0 : size_m1[sccb_pkg::SIZE_W-1:sccb_pkg::UNIT_SHIFT];
	assign cidx = (item_q.cmd == sccb_pkg::CMD_ALLOC) ? cls_q[CW-1:0]
		: item_q.block_class[CW-1:0];
	assign class_val = cvalid_q[cidx] ? class_rd : '0;
	assign link_val = lvalid_q[lrd_idx_q] ? link_rd : link_reset(lrd_idx_q);
	assign fh_m1 = fh_q - LW'(1);
	assign fh_e = fh_m1[EW-1:0];
	assign cls_big = int'(cls_q) >= NC;
	assign cls_units = UW'(cls_q) + UW'(2);
	assign dec = cls_units;
	assign total_sub = (total_q >= dec) ? total_q - dec : '0;
	assign sum = {1'b0, total_q} + (UW+1)'(item_q.block_class) + (UW+1)'(2);
	assign total_add = sum[UW] ? '1 : sum[UW-1:0];

	always_comb begin
		state_d = state_q;
		fh_d = fh_q;
		total_d = total_q;
		cursor_d = cursor_q;
		cvalid_d = cvalid_q;
		lvalid_d = lvalid_q;
		occ_d = occ_q;
		collect_d = collect_q;
		flushed_d = flushed_q;
		pop_e_d = pop_e_q;
		pop_head_d = pop_head_q;
		lrd_idx_d = lrd_idx_q;
		load = 1'b0;
		in_stall = 1'b1;
		emit = '0;
		class_req = '0;
		link_req = '0;
		hdl_req = '0;
		unique case (state_q)
			sccb_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load = 1'b1;
					unique case (in_item.cmd)
						sccb_pkg::CMD_ALLOC: begin
							class_req.re = 1'b1;
							class_req.raddr = cls_in[CW-1:0];
							state_d = sccb_pkg::S_LOOKUP;
						end
						sccb_pkg::CMD_FREE: begin
							class_req.re = 1'b1;
							class_req.raddr = in_item.block_class[CW-1:0];
							link_req.re = 1'b1;
							link_req.raddr = fh_e;
							lrd_idx_d = fh_e;
							flushed_d = 1'b0;
							state_d = sccb_pkg::S_LOOKUP;
						end
						sccb_pkg::CMD_COLLECT: begin
							collect_d = 1'b1;
							total_d = '0;
							cursor_d = '0;
							state_d = sccb_pkg::S_FLUSH_RD;
						end
						sccb_pkg::CMD_RSVD: begin
							state_d = sccb_pkg::S_IDLE;
						end
					endcase
				end
			end
			sccb_pkg::S_LOOKUP: begin
				if (item_q.cmd == sccb_pkg::CMD_ALLOC) begin
					if (!cls_big && class_val != '0 && int'(class_val) <= NE) begin
						pop_e_d = EW'(class_val - LW'(1));
						pop_head_d = class_val;
						link_req.re = 1'b1;
						link_req.raddr = EW'(class_val - LW'(1));
						hdl_req.re = 1'b1;
						hdl_req.raddr = EW'(class_val - LW'(1));
						lrd_idx_d = EW'(class_val - LW'(1));
						state_d = sccb_pkg::S_POP;
					end else if (out_ready) begin
						emit.valid = 1'b1;
						emit.item.status = sccb_pkg::ST_MISS;
						emit.item.size_class = cls_big ? sccb_pkg::OVERSIZED_CODE
							: sccb_pkg::BCLS_W'(cls_q);
						emit.item.request_bytes = {cls_units, {sccb_pkg::UNIT_SHIFT{1'b0}}};
						emit.item.cached_units = total_q;
						emit.item.last = 1'b1;
						state_d = sccb_pkg::S_IDLE;
					end
				end else if (!item_q.header_ok) begin
					if (out_ready) begin
						emit.valid = 1'b1;
						emit.item.status = sccb_pkg::ST_CORRUPT;
						emit.item.cached_units = total_q;
						emit.item.last = 1'b1;
						state_d = sccb_pkg::S_IDLE;
					end
				end else if (int'(item_q.block_class) >= NC) begin
					if (out_ready) begin
						emit.valid = 1'b1;
						emit.item.status = sccb_pkg::ST_OVERSIZE;
						emit.item.out_handle = item_q.handle;
						emit.item.cached_units = total_q;
						emit.item.last = 1'b1;
						state_d = sccb_pkg::S_IDLE;
					end
				end else if (!flushed_q && (fh_q == '0 || int'(fh_q) > NE || total_q >= limit)) begin
					collect_d = 1'b0;
					total_d = '0;
					cursor_d = '0;
					state_d = sccb_pkg::S_FLUSH_RD;
				end else if (out_ready) begin
					link_req.we = 1'b1;
					link_req.waddr = fh_e;
					link_req.wdata = class_val;
					lvalid_d[fh_e] = 1'b1;
					class_req.we = 1'b1;
					class_req.waddr = item_q.block_class[CW-1:0];
					class_req.wdata = fh_q;
					cvalid_d[item_q.block_class[CW-1:0]] = 1'b1;
					hdl_req.we = 1'b1;
					hdl_req.waddr = fh_e;
					hdl_req.wdata = item_q.handle;
					occ_d[fh_e] = 1'b1;
					fh_d = link_val;
					total_d = total_add;
					flushed_d = 1'b0;
					emit.valid = 1'b1;
					emit.item.status = sccb_pkg::ST_CACHED;
					emit.item.cached_units = total_add;
					emit.item.last = 1'b1;
					state_d = sccb_pkg::S_IDLE;
				end
			end
			sccb_pkg::S_POP: begin
				if (out_ready) begin
					class_req.we = 1'b1;
					class_req.waddr = cls_q[CW-1:0];
					class_req.wdata = link_val;
					cvalid_d[cls_q[CW-1:0]] = 1'b1;
					link_req.we = 1'b1;
					link_req.waddr = pop_e_q;
					link_req.wdata = fh_q;
					lvalid_d[pop_e_q] = 1'b1;
					occ_d[pop_e_q] = 1'b0;
					fh_d = pop_head_q;
					total_d = total_sub;
					emit.valid = 1'b1;
					emit.item.status = sccb_pkg::ST_HIT;
					emit.item.out_handle = hdl_rd;
					emit.item.size_class = sccb_pkg::BCLS_W'(cls_q);
					emit.item.cached_units = total_sub;
					emit.item.last = 1'b1;
					state_d = sccb_pkg::S_IDLE;
				end
			end
			sccb_pkg::S_FLUSH_RD: begin
				hdl_req.re = 1'b1;
				hdl_req.raddr = cursor_q;
				state_d = sccb_pkg::S_FLUSH_EM;
			end
			sccb_pkg::S_FLUSH_EM: begin
				if (!occ_q[cursor_q] || out_ready) begin
					if (occ_q[cursor_q]) begin
						emit.valid = 1'b1;
						emit.item.status = sccb_pkg::ST_FLUSH;
						emit.item.out_handle = hdl_rd;
					end
					if (int'(cursor_q) == NE - 1) begin
						cvalid_d = '0;
						lvalid_d = '0;
						occ_d = '0;
						fh_d = LW'(1);
						total_d = '0;
						cursor_d = '0;
						state_d = collect_q ? sccb_pkg::S_DONE : sccb_pkg::S_REREAD;
					end else begin
						cursor_d = cursor_q + EW'(1);
						state_d = sccb_pkg::S_FLUSH_RD;
					end
				end
			end
			sccb_pkg::S_REREAD: begin
				class_req.re = 1'b1;
				class_req.raddr = item_q.block_class[CW-1:0];
				link_req.re = 1'b1;
				link_req.raddr = fh_e;
				lrd_idx_d = fh_e;
				flushed_d = 1'b1;
				state_d = sccb_pkg::S_LOOKUP;
			end
			sccb_pkg::S_DONE: begin
				if (out_ready) begin
					emit.valid = 1'b1;
					emit.item.status = sccb_pkg::ST_COLLECT;
					emit.item.last = 1'b1;
					state_d = sccb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sccb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sccb_pkg::S_IDLE;
			fh_q <= LW'(1);
			total_q <= '0;
			cursor_q <= '0;
			cvalid_q <= '0;
			lvalid_q <= '0;
			occ_q <= '0;
			collect_q <= 1'b0;
			flushed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fh_q <= fh_d;
			total_q <= total_d;
			cursor_q <= cursor_d;
			cvalid_q <= cvalid_d;
			lvalid_q <= lvalid_d;
			occ_q <= occ_d;
			collect_q <= collect_d;
			flushed_q <= flushed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= in_item;
			cls_q <= cls_in;
		end
		pop_e_q <= pop_e_d;
		pop_head_q <= pop_head_d;
		lrd_idx_q <= lrd_idx_d;
	end

endmodule

FILE: hw/rtl/size_class_block_cache.sv
// top level of the size class block cache: register port, memories, result register
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall   in_item (cmd, size, handle, class, header)
// out      output     out_valid / out_stall out_item (status, handle, class, bytes, units)
// apb      input      psel penable pready   cache_limit_units at byte address 0
//
// an alloc miss, a free and a corrupt or oversized free report after the class head
// read; an alloc hit reads the class head, then the entry link and handle.
// a flush walks all entries through the handle ram read port in S_FLUSH_RD/S_FLUSH_EM;
// after the walk a free rereads (S_REREAD) and a collect reports (S_DONE).
// reset empties every list through valid bits at once; no clearing pass is needed.
// a stalled output holds its item; the next item is taken while it waits.
`timescale 1ns / 1ps
module size_class_block_cache (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  sccb_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output sccb_pkg::out_item_t              out_item,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sccb_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sccb_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sccb_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	logic [sccb_pkg::UNITS_W-1:0] limit_q;
	logic                         reg_sel;

	logic                 out_valid_q;
	sccb_pkg::out_item_t  out_item_q;
	logic                 out_ready;
	sccb_pkg::emit_t      emit;

	sccb_pkg::class_req_t class_req;
	sccb_pkg::link_req_t  link_req;
	sccb_pkg::hdl_req_t   hdl_req;
	logic [sccb_pkg::LNK_W-1:0]    class_rd;
	logic [sccb_pkg::LNK_W-1:0]    link_rd;
	logic [sccb_pkg::HANDLE_W-1:0] hdl_rd;

	assign pready = 1'b1;
	assign reg_sel = (paddr[sccb_pkg::APB_ADDR_W-1] == 1'b0);
	assign prdata = reg_sel ? sccb_pkg::APB_DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sccb_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[sccb_pkg::UNITS_W-1:0];
		end
	end

	sccb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_ready (out_ready),
		.emit      (emit),
		.limit     (limit_q),
		.class_req (class_req),
		.class_rd  (class_rd),
		.link_req  (link_req),
		.link_rd   (link_rd),
		.hdl_req   (hdl_req),
		.hdl_rd    (hdl_rd)
	);

	sccb_ram #(
		.DEPTH (sccb_pkg::NUM_CLASSES),
		.WIDTH (sccb_pkg::LNK_W)
	) u_class_heads (
		.clk   (clk),
		.we    (class_req.we),
		.waddr (class_req.waddr),
		.wdata (class_req.wdata),
		.re    (class_req.re),
		.raddr (class_req.raddr),
		.rdata (class_rd)
	);

	sccb_ram #(
		.DEPTH (sccb_pkg::NUM_ENTRIES),
		.WIDTH (sccb_pkg::LNK_W)
	) u_entry_links (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rd)
	);

	sccb_ram #(
		.DEPTH (sccb_pkg::NUM_ENTRIES),
		.WIDTH (sccb_pkg::HANDLE_W)
	) u_entry_handles (
		.clk   (clk),
		.we    (hdl_req.we),
		.waddr (hdl_req.waddr),
		.wdata (hdl_req.wdata),
		.re    (hdl_req.re),
		.raddr (hdl_req.raddr),
		.rdata (hdl_rd)
	);

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_item_q <= emit.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	a_flush_units_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == sccb_pkg::ST_FLUSH
			|| out_item.status == sccb_pkg::ST_COLLECT) |-> out_item.cached_units == '0)
		else $error("flush or collect result with nonzero cached units");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == sccb_pkg::ST_HIT
			|-> out_item.size_class != sccb_pkg::OVERSIZED_CODE)
		else $error("hit reported for oversized class");

	a_flush_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == sccb_pkg::ST_FLUSH |-> !out_item.last)
		else $error("flush release marked as final item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.cmd != sccb_pkg::CMD_RSVD |=> in_stall)
		else $error("input taken while previous item still in work");

endmodule

FILE: bench/sccb_checker.sv
// checker for the size class block cache: watches the stream ports and apb writes, predicts results and compares
`timescale 1ns / 1ps
module sccb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  sccb_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  sccb_pkg::out_item_t             out_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [sccb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sccb_pkg::APB_DATA_W-1:0] pwdata,
	output int                              fail_count,
	output int                              pending,
	output int                              checked,
	output int                              flushes
);

	localparam int NC = sccb_pkg::NUM_CLASSES;
	localparam int NE = sccb_pkg::NUM_ENTRIES;
	localparam int LW = sccb_pkg::LNK_W;
	localparam int EW = sccb_pkg::ENT_W;
	localparam int CW = sccb_pkg::CLS_W;
	localparam int FW = sccb_pkg::CLS_FULL_W;
	localparam int SW = sccb_pkg::SIZE_W;
	localparam int BW = sccb_pkg::BCLS_W;
	localparam int HW = sccb_pkg::HANDLE_W;
	localparam int RW = sccb_pkg::REQ_W;
	localparam int UW = sccb_pkg::UNITS_W;
	localparam int US = sccb_pkg::UNIT_SHIFT;

	logic [LW-1:0]       class_top [NC];
	logic [HW-1:0]       slot_handle [NE];
	logic [LW-1:0]       slot_next [NE];
	logic                slot_busy [NE];
	logic [LW-1:0]       spare_top;
	logic [UW-1:0]       units_held;
	logic [UW-1:0]       limit_units;
	sccb_pkg::out_item_t cache_results [$];
	sccb_pkg::out_item_t held;
	bit                  have_held;

	task automatic rebuild_pool();
		int i;
		for (i = 0; i < NC; i++) class_top[i] = '0;
		for (i = 0; i < NE; i++) begin
			slot_next[i] = (i + 1 < NE) ? LW'(i + 2) : '0;
			slot_busy[i] = 1'b0;
		end
		spare_top = LW'(1);
		units_held = '0;
	endtask

	task automatic add_result(input sccb_pkg::status_t st, input logic [HW-1:0] h,
			input logic [BW-1:0] cls, input logic [RW-1:0] req,
			input logic [UW-1:0] units);
		if (have_held) cache_results.push_back(held);
		held.status = st;
		held.out_handle = h;
		held.size_class = cls;
		held.request_bytes = req;
		held.cached_units = units;
		held.last = 1'b0;
		have_held = 1'b1;
	endtask

	task automatic flush_cache();
		int i;
		units_held = '0;
		for (i = 0; i < NE; i++)
			if (slot_busy[i]) add_result(sccb_pkg::ST_FLUSH, slot_handle[i], '0, '0, '0);
		rebuild_pool();
		flushes++;
	endtask

	task automatic predict_item(input sccb_pkg::in_item_t it);
		logic [SW-1:0] size_m1;
		logic [FW-1:0] cls;
		logic [BW-1:0] code;
		logic [LW-1:0] head;
		logic [LW-1:0] link;
		logic [EW-1:0] e;
		int            c2;
		int            sum;
		size_m1 = it.size_bytes - SW'(1);
		cls = (it.size_bytes == '0) ? '0 : size_m1[SW-1:US];
		c2 = int'(cls) + 2;
		code = (int'(cls) < NC) ? cls[BW-1:0] : sccb_pkg::OVERSIZED_CODE;
		head = (int'(cls) < NC) ? class_top[cls[CW-1:0]] : '0;
		unique case (it.cmd)
			sccb_pkg::CMD_ALLOC: begin
				if (head != '0 && int'(head) <= NE) begin
					e = EW'(head - LW'(1));
					class_top[cls[CW-1:0]] = slot_next[e];
					slot_next[e] = spare_top;
					slot_busy[e] = 1'b0;
					spare_top = head;
					units_held = (int'(units_held) >= c2) ? UW'(int'(units_held) - c2) : '0;
					add_result(sccb_pkg::ST_HIT, slot_handle[e], code, '0, units_held);
				end else begin
					add_result(sccb_pkg::ST_MISS, '0, code, RW'(c2 << US), units_held);
				end
			end
			sccb_pkg::CMD_FREE: begin
				if (!it.header_ok) begin
					add_result(sccb_pkg::ST_CORRUPT, '0, '0, '0, units_held);
				end else if (int'(it.block_class) >= NC) begin
					add_result(sccb_pkg::ST_OVERSIZE, it.handle, '0, '0, units_held);
				end else begin
					if (spare_top == '0 || int'(spare_top) > NE || units_held >= limit_units)
						flush_cache();
					e = EW'(spare_top - LW'(1));
					link = slot_next[e];
					slot_next[e] = class_top[it.block_class[CW-1:0]];
					class_top[it.block_class[CW-1:0]] = spare_top;
					spare_top = link;
					slot_handle[e] = it.handle;
					slot_busy[e] = 1'b1;
					sum = int'(units_held) + int'(it.block_class) + 2;
					units_held = (sum > (1 << UW) - 1) ? '1 : UW'(sum);
					add_result(sccb_pkg::ST_CACHED, '0, '0, '0, units_held);
				end
			end
			sccb_pkg::CMD_COLLECT: begin
				flush_cache();
				add_result(sccb_pkg::ST_COLLECT, '0, '0, '0, '0);
			end
			sccb_pkg::CMD_RSVD: ;
		endcase
		if (have_held) begin
			held.last = 1'b1;
			cache_results.push_back(held);
			have_held = 1'b0;
		end
	endtask

	task automatic report_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		fail_count++;
		$display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sccb_pkg::out_item_t want;
		if (!arst_n) begin
			limit_units = sccb_pkg::LIMIT_RESET;
			rebuild_pool();
			cache_results.delete();
			have_held = 1'b0;
			fail_count = 0;
			checked = 0;
			flushes = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (cache_results.size() == 0) begin
					fail_count++;
					$display("%0t: result expected none actual %0h", $time, out_item);
				end else begin
					want = cache_results.pop_front();
					if (out_item.status !== want.status)
						report_field("status", 64'(want.status), 64'(out_item.status));
					if (out_item.out_handle !== want.out_handle)
						report_field("out_handle", 64'(want.out_handle),
							64'(out_item.out_handle));
					if (out_item.size_class !== want.size_class)
						report_field("size_class", 64'(want.size_class),
							64'(out_item.size_class));
					if (out_item.request_bytes !== want.request_bytes)
						report_field("request_bytes", 64'(want.request_bytes),
							64'(out_item.request_bytes));
					if (out_item.cached_units !== want.cached_units)
						report_field("cached_units", 64'(want.cached_units),
							64'(out_item.cached_units));
					if (out_item.last !== want.last)
						report_field("last", 64'(want.last), 64'(out_item.last));
				end
			end
			if (psel && penable && pwrite && pready && paddr == sccb_pkg::LIMIT_ADDR)
				limit_units = pwdata[UW-1:0];
			if (in_valid && !in_stall) predict_item(in_item);
			pending <= cache_results.size();
		end
	end

endmodule

FILE: bench/size_class_block_cache_tb.sv
// testbench top of the size class block cache: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module size_class_block_cache_tb;

	localparam int AW = sccb_pkg::APB_ADDR_W;
	localparam int DW = sccb_pkg::APB_DATA_W;
	localparam int SW = sccb_pkg::SIZE_W;
	localparam int HW = sccb_pkg::HANDLE_W;
	localparam int BW = sccb_pkg::BCLS_W;
	localparam int UW = sccb_pkg::UNITS_W;
	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 52;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	sccb_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	sccb_pkg::out_item_t out_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AW-1:0]       paddr;
	logic [DW-1:0]       pwdata;
	logic [DW-1:0]       prdata;
	logic                pready;

	int fail_count;
	int pending;
	int checked;
	int flushes;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked = 0;
	int sent = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	size_class_block_cache uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sccb_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending), .checked(checked), .flushes(flushes)
	);

	function automatic sccb_pkg::in_item_t mk(input sccb_pkg::cmd_t c,
			input logic [SW-1:0] sz, input logic [HW-1:0] h, input logic [BW-1:0] bc,
			input logic ok);
		sccb_pkg::in_item_t it;
		it.cmd = c;
		it.size_bytes = sz;
		it.handle = h;
		it.block_class = bc;
		it.header_ok = ok;
		return it;
	endfunction

	function automatic sccb_pkg::in_item_t random_item();
		logic [63:0]   r;
		logic [SW-1:0] sz;
		logic [BW-1:0] bc;
		int            p;
		int            q;
		r = {$urandom, $urandom};
		q = $urandom_range(0, 99);
		if (q < 75) bc = BW'($urandom_range(0, 7));
		else if (q < 95) bc = BW'($urandom_range(0, 63));
		else bc = sccb_pkg::OVERSIZED_CODE;
		q = $urandom_range(0, 99);
		if (q < 75) sz = SW'(($urandom_range(0, 7) << 3) + $urandom_range(1, 8));
		else if (q < 85) sz = SW'(($urandom_range(0, 63) << 3) + $urandom_range(1, 8));
		else if (q < 90) sz = '0;
		else sz = SW'($urandom);
		p = $urandom_range(0, 99);
		if (p < 48)
			return mk(sccb_pkg::CMD_FREE, SW'($urandom), r[HW-1:0], bc, 1'b1);
		else if (p < 88)
			return mk(sccb_pkg::CMD_ALLOC, sz, r[HW-1:0], bc, r[63]);
		else if (p < 91)
			return mk(sccb_pkg::CMD_COLLECT, sz, r[HW-1:0], bc, r[63]);
		else if (p < 96)
			return mk(sccb_pkg::CMD_FREE, sz, r[HW-1:0], BW'($urandom_range(0, 64)), 1'b0);
		else
			return mk(sccb_pkg::CMD_RSVD, sz, r[HW-1:0], bc, r[63]);
	endfunction

	task automatic send_item(input sccb_pkg::in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.cmd != sccb_pkg::CMD_RSVD) sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [UW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sccb_pkg::LIMIT_ADDR;
		pwdata <= DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_random(input int n);
		sccb_pkg::in_item_t it;
		int start;
		start = sent;
		while (sent - start < n) begin
			it = random_item();
			send_item(it);
		end
	endtask

	task automatic run_directed();
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd0, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'hFFFFFF, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd512, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd513, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h0, 7'd0, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'hFFFFFFFFFFFF, 7'd63, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h123456789ABC, 7'd5, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'hFEDCBA987654, 7'd5, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd48, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd41, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd41, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd1, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd8, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd9, '0, '0, 1'b1));
		// corrupt header wins over an oversized class
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'hAAAA5555AAAA, sccb_pkg::OVERSIZED_CODE, 1'b0));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h555555555555, 7'd3, 1'b0));
		send_item(mk(sccb_pkg::CMD_FREE, 24'hFFFFFF, 48'hFFFFFFFFFFFF,
			sccb_pkg::OVERSIZED_CODE, 1'b1));
		send_item(mk(sccb_pkg::CMD_RSVD, 24'hFFFFFF, 48'hFFFFFFFFFFFF, 7'h7F, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h00000000BEEF, 7'd10, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h800000000001, 7'd20, 1'b1));
		send_item(mk(sccb_pkg::CMD_COLLECT, '0, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_COLLECT, '0, '0, '0, 1'b0));
		send_item(mk(sccb_pkg::CMD_ALLOC, 24'd504, '0, '0, 1'b1));
		send_item(mk(sccb_pkg::CMD_FREE, '0, 48'h0F0F0F0F0F0F, 7'd1, 1'b1));
	endtask

	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin
		while (cycles < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 6;
		recv_idle_pct = 75;
		write_limit(22'h3FFFFF);
		run_directed();
		drain();

		write_limit(22'd1);
		run_random(PHASE_ITEMS);
		drain();

		send_idle_pct = 75;
		recv_idle_pct = 6;
		write_limit(22'd40);
		run_random(PHASE_ITEMS);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(sccb_pkg::LIMIT_RESET);
		// output held off while items keep coming
		hold_asked++;
		run_random(PHASE_ITEMS);
		drain();

		$display("covered %0d items: directed cases, then random mixes under limits 1, 40, 2097152",
			sent);
		$display("%0d results compared, %0d flushes predicted", checked, flushes);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: size_class_block_cache.f
hw/rtl/sccb_pkg.sv
hw/rtl/sccb_ram.sv
hw/rtl/sccb_ctrl.sv
hw/rtl/size_class_block_cache.sv
bench/sccb_checker.sv
bench/size_class_block_cache_tb.sv
